// ===== rtl/ljlr_pkg.sv =====
// ljlr_pkg: shared constants, register codes and types for the line reconstruct unit
// no dependencies; imported by every module of the block

package ljlr_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_BANDS   = 4;

    localparam int SAMPLE_W    = 16;
    localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int BAND_W      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int WCNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int BCNT_W      = $clog2(MAX_BANDS + 1);
    localparam int MEM_DEPTH   = MAX_WIDTH * MAX_BANDS;
    localparam int SLOT_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // configuration register fields, fixed widths
    localparam int PRED_W      = 3;
    localparam int PREC_W      = 5;
    localparam int PT_W        = 4;
    localparam int LWIDTH_W    = 13;
    localparam int BANDS_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREDICTOR       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_TRANSFORM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES    = 3'd5;

    // predictor selects
    localparam logic [PRED_W-1:0] PRED_LEFT       = 3'd0;
    localparam logic [PRED_W-1:0] PRED_ABOVE      = 3'd1;
    localparam logic [PRED_W-1:0] PRED_UPPER_LEFT = 3'd2;
    localparam logic [PRED_W-1:0] PRED_PLANE      = 3'd3;
    localparam logic [PRED_W-1:0] PRED_LEFT_HALF  = 3'd4;
    localparam logic [PRED_W-1:0] PRED_ABOVE_HALF = 3'd5;
    localparam logic [PRED_W-1:0] PRED_AVERAGE    = 3'd6;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SLOT_W-1:0]   t_slot;

    typedef struct packed {
        logic [PRED_W-1:0]  predictor;
        logic [PREC_W-1:0]  precision;
        logic [PT_W-1:0]    point_transform;
        logic [WCNT_W-1:0]  width_eff;
        logic [BCNT_W-1:0]  bands_eff;
        logic               wide;
        logic               cfg_err;
    } t_cfg;

endpackage

// ===== rtl/lossless_jpeg_line_reconstruct_unit.sv =====
// lossless_jpeg_line_reconstruct_unit: top level, scan counters, two-stage pipeline
// depends on ljlr_pkg, ljlr_cfg_regs, ljlr_line_mem, ljlr_recon
//
// usage:
// - s_axis carries one prediction difference per transaction, bands interleaved
//   in raster order; tuser marks a restart or first line and is sampled only on
//   the first sample of a line
// - m_axis returns one reconstructed sample per input transaction, tlast on the
//   last band of the last pixel of a line, tuser set on a bad point transform
// - cfg writes a register by index; write only while the stream is idle
// - throughput: one sample per cycle while m_axis is ready; the previous-line
//   memory is read in the accept cycle and the result is formed in the cycle
//   after it
// - path: input stage, then output register, which drives m_axis
// - reset: registers return to defaults, and the previous-line memory is
//   zeroed one entry per cycle, all 16384 entries (MAX_WIDTH * MAX_BANDS), while
//   s_axis tready stays low; cfg writes are taken during that sweep
// - stall: a held result on m_axis keeps one more sample in the input stage,
//   after which s_axis tready drops until the receiver takes the result

module lossless_jpeg_line_reconstruct_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [15:0]                    i_s_axis_tdata,  // [15:0] diff
    input  logic [0:0]                     i_s_axis_tuser,  // [0] restart
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [15:0]                    o_m_axis_tdata,  // [15:0] sample
    output logic                           o_m_axis_tlast,
    output logic [0:0]                     o_m_axis_tuser,  // [0] config_error
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ljlr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ljlr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ljlr_pkg::*;

    t_cfg               cfg;
    logic               mem_busy;
    t_sample            mem_rd;

    logic [COL_W-1:0]   r_col;
    logic [BAND_W-1:0]  r_band;
    logic               r_restart_line;
    logic [COL_W-1:0]   n_col;
    logic [BAND_W-1:0]  n_band;
    logic               n_restart_line;

    logic               r_s1_vld;
    logic signed [15:0] r_s1_diff;
    logic [BAND_W-1:0]  r_s1_band;
    logic               r_s1_col_zero;
    logic               r_s1_restart;
    logic               r_s1_last;
    t_slot              r_s1_slot;
    logic               r_s1_fwd;
    t_sample            r_s1_fwd_data;

    t_sample            r_left  [MAX_BANDS];
    t_sample            r_upper [MAX_BANDS];

    logic               r_out_vld;
    t_sample            r_out_sample;
    logic               r_out_last;
    logic               r_out_err;

    logic               s_acc;
    logic               s1_adv;
    logic               first_pos;
    logic               last_band;
    logic               last_col;
    t_slot              slot_now;
    t_sample            above;
    t_sample            result;

    ljlr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign s1_adv          = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !mem_busy && (!r_s1_vld || s1_adv);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // scan position
    always_comb begin
        first_pos = (r_col == '0) && (r_band == '0);
        last_band = (BCNT_W'(r_band) + 1'b1) >= cfg.bands_eff;
        last_col  = (WCNT_W'(r_col) + 1'b1) >= cfg.width_eff;
        slot_now  = SLOT_W'(r_col) * SLOT_W'(MAX_BANDS) + SLOT_W'(r_band);

        n_restart_line = first_pos ? i_s_axis_tuser[0] : r_restart_line;
        n_band         = r_band;
        n_col          = r_col;
        if (last_band) begin
            n_band = '0;
            n_col  = last_col ? '0 : r_col + 1'b1;
        end else begin
            n_band = r_band + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_band         <= '0;
            r_restart_line <= 1'b0;
        end else if (s_acc) begin
            r_col          <= n_col;
            r_band         <= n_band;
            r_restart_line <= n_restart_line;
        end
    end

    ljlr_line_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_addr (slot_now),
        .o_rd_data (mem_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_slot),
        .i_wr_data (result),
        .o_busy    (mem_busy)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_vld <= 1'b0;
        else if (s_acc)
            r_s1_vld <= 1'b1;
        else if (s1_adv)
            r_s1_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_diff     <= i_s_axis_tdata;
            r_s1_band     <= r_band;
            r_s1_col_zero <= (r_col == '0);
            r_s1_restart  <= n_restart_line;
            r_s1_last     <= last_band && last_col;
            r_s1_slot     <= slot_now;
            // same-edge write to the slot being read
            r_s1_fwd      <= s1_adv && (r_s1_slot == slot_now);
            r_s1_fwd_data <= result;
        end
    end

    assign above = r_s1_fwd ? r_s1_fwd_data : mem_rd;

    ljlr_recon u_recon (
        .i_cfg        (cfg),
        .i_left       (r_left[r_s1_band]),
        .i_above      (above),
        .i_upper_left (r_upper[r_s1_band]),
        .i_diff       (r_s1_diff),
        .i_col_zero   (r_s1_col_zero),
        .i_restart    (r_s1_restart),
        .o_result     (result)
    );

    // per-band neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BANDS; i++) begin
                r_left[i]  <= '0;
                r_upper[i] <= '0;
            end
        end else if (s1_adv) begin
            r_left[r_s1_band]  <= result;
            r_upper[r_s1_band] <= above;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_vld <= 1'b0;
        else if (s1_adv)
            r_out_vld <= 1'b1;
        else if (i_m_axis_tready)
            r_out_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_sample <= result;
            r_out_last   <= r_s1_last;
            r_out_err    <= cfg.cfg_err;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_sample;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

endmodule

// ===== rtl/ljlr_cfg_regs.sv =====
// ljlr_cfg_regs: configuration register file with clamped line geometry and error flag
// depends on ljlr_pkg

module ljlr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ljlr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ljlr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ljlr_pkg::t_cfg                 o_cfg
);
    import ljlr_pkg::*;

    logic [PRED_W-1:0]   r_predictor;
    logic [PREC_W-1:0]   r_precision;
    logic [PT_W-1:0]     r_point_transform;
    logic [LWIDTH_W-1:0] r_line_width;
    logic [BANDS_W-1:0]  r_band_count;
    logic                r_wide;
    logic                cfg_we;
    logic [31:0]         lw_ext;
    logic [31:0]         bc_ext;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_predictor       <= PRED_LEFT;
            r_precision       <= PREC_W'(8);
            r_point_transform <= '0;
            r_line_width      <= LWIDTH_W'(1);
            r_band_count      <= BANDS_W'(1);
            r_wide            <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_PREDICTOR:       r_predictor       <= i_cfg_data[PRED_W-1:0];
                CFG_PRECISION:       r_precision       <= i_cfg_data[PREC_W-1:0];
                CFG_POINT_TRANSFORM: r_point_transform <= i_cfg_data[PT_W-1:0];
                CFG_LINE_WIDTH:      r_line_width      <= i_cfg_data[LWIDTH_W-1:0];
                CFG_BAND_COUNT:      r_band_count      <= i_cfg_data[BANDS_W-1:0];
                CFG_WIDE_SAMPLES:    r_wide            <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero reads as one, large values saturate
    always_comb begin
        lw_ext = 32'(r_line_width);
        bc_ext = 32'(r_band_count);
        if (lw_ext == 32'd0)
            lw_ext = 32'd1;
        if (lw_ext > 32'(MAX_WIDTH))
            lw_ext = 32'(MAX_WIDTH);
        if (bc_ext == 32'd0)
            bc_ext = 32'd1;
        if (bc_ext > 32'(MAX_BANDS))
            bc_ext = 32'(MAX_BANDS);
    end

    always_comb begin
        o_cfg.predictor       = r_predictor;
        o_cfg.precision       = r_precision;
        o_cfg.point_transform = r_point_transform;
        o_cfg.width_eff       = WCNT_W'(lw_ext);
        o_cfg.bands_eff       = BCNT_W'(bc_ext);
        o_cfg.wide            = r_wide;
        o_cfg.cfg_err         = {1'b0, r_point_transform} >= r_precision;
    end

endmodule

// ===== rtl/ljlr_line_mem.sv =====
// ljlr_line_mem: previous-line sample memory, registered read, zeroing sweep after reset
// depends on ljlr_pkg

module ljlr_line_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  ljlr_pkg::t_slot   i_rd_addr,
    output ljlr_pkg::t_sample o_rd_data,
    input  logic              i_wr_en,
    input  ljlr_pkg::t_slot   i_wr_addr,
    input  ljlr_pkg::t_sample i_wr_data,
    output logic              o_busy
);
    import ljlr_pkg::*;

    t_sample r_mem [MEM_DEPTH];
    t_sample r_rd_data;
    logic    r_clr_busy;
    t_slot   r_clr_addr;
    logic    wr_en;
    t_slot   wr_addr;
    t_sample wr_data;

    always_comb begin
        wr_en   = i_wr_en;
        wr_addr = i_wr_addr;
        wr_data = i_wr_data;
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == SLOT_W'(MEM_DEPTH - 1))
                r_clr_busy <= 1'b0;
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[wr_addr] <= wr_data;
        if (i_rd_en)
            r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// ===== rtl/ljlr_recon.sv =====
// ljlr_recon: neighbor decode, predictor select and difference add for one sample
// depends on ljlr_pkg

module ljlr_recon (
    input  ljlr_pkg::t_cfg    i_cfg,
    input  ljlr_pkg::t_sample i_left,
    input  ljlr_pkg::t_sample i_above,
    input  ljlr_pkg::t_sample i_upper_left,
    input  logic signed [15:0] i_diff,
    input  logic              i_col_zero,
    input  logic              i_restart,
    output ljlr_pkg::t_sample o_result
);
    import ljlr_pkg::*;

    logic signed [16:0] a;
    logic signed [16:0] b;
    logic signed [16:0] c;
    logic signed [18:0] d_bc;
    logic signed [18:0] d_ac;
    logic signed [18:0] s_ab;
    logic signed [18:0] pred;
    logic [15:0]        mask;
    logic [4:0]         first_sh;
    logic [15:0]        first_pred;
    logic signed [18:0] sum;

    function automatic logic signed [16:0] read_nb(input t_sample v, input logic wide);
        logic signed [16:0] r;
        if (wide)
            r = {v[15], v};
        else
            r = {9'b0, v[7:0]};
        return r;
    endfunction

    always_comb begin
        a    = read_nb(i_left, i_cfg.wide);
        b    = read_nb(i_above, i_cfg.wide);
        c    = read_nb(i_upper_left, i_cfg.wide);
        mask = i_cfg.wide ? 16'hFFFF : 16'h00FF;
        d_bc = 19'(b) - 19'(c);
        d_ac = 19'(a) - 19'(c);
        s_ab = 19'(a) + 19'(b);

        first_sh   = i_cfg.precision - 5'(i_cfg.point_transform) - 5'd1;
        first_pred = i_cfg.cfg_err ? 16'd0 : ((16'd1 << first_sh) & mask);

        if (i_col_zero) begin
            if (i_restart)
                pred = 19'(first_pred);
            else
                pred = 19'(b);
        end else if (i_restart) begin
            pred = 19'(a);
        end else begin
            case (i_cfg.predictor)
                PRED_LEFT:       pred = 19'(a);
                PRED_ABOVE:      pred = 19'(b);
                PRED_UPPER_LEFT: pred = 19'(c);
                PRED_PLANE:      pred = 19'(a) + d_bc;
                PRED_LEFT_HALF:  pred = 19'(a) + (d_bc >>> 1);
                PRED_ABOVE_HALF: pred = 19'(b) + (d_ac >>> 1);
                PRED_AVERAGE:    pred = s_ab >>> 1;
                default:         pred = '0;
            endcase
        end

        sum      = pred + 19'(i_diff);
        o_result = sum[15:0] & mask;
    end

endmodule
